### hdl/seed_key_security_access_macros.svh
// Assertion macros shared by the seed/key unlock engine modules.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef SEED_KEY_SECURITY_ACCESS_MACROS_SVH
`define SEED_KEY_SECURITY_ACCESS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SKSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SKSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sak_pkg.sv
// Shared types, codes and helpers for the seed/key unlock engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package sak_pkg;

	// Operation codes of a request word
	typedef enum logic [1:0] {
		OP_SEED  = 2'd0,
		OP_KEY   = 2'd1,
		OP_TICK  = 2'd2,
		OP_CLEAR = 2'd3
	} sak_op_t;

	// Response status
	typedef enum logic [1:0] {
		ST_POS   = 2'd0,
		ST_NEG   = 2'd1,
		ST_PARAM = 2'd2
	} sak_status_t;

	// Negative response codes
	typedef enum logic [2:0] {
		NRC_NONE     = 3'd0,
		NRC_SUBFN    = 3'd1,
		NRC_ATTEMPTS = 3'd2,
		NRC_SEQUENCE = 3'd3,
		NRC_DELAY    = 3'd4,
		NRC_LENGTH   = 3'd5,
		NRC_KEY      = 3'd6
	} sak_nrc_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_LOCKOUT  = 2'd0,
		REG_TIMEOUT  = 2'd1,
		REG_ATTEMPTS = 2'd2,
		REG_MASK     = 2'd3
	} sak_reg_t;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 32;

	// Register reset values
	localparam logic [15:0] LOCKOUT_RESET  = 16'd300;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd10;
	localparam logic [7:0]  ATTEMPTS_RESET = 8'd3;
	localparam logic [31:0] KEY_MASK_RESET = 32'hABCD1234;

	// Request word
	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  sub_function;
		logic [31:0] key_value;
		logic [7:0]  key_length;
		logic [31:0] fresh_seed;
	} sak_req_t;

	// Response word
	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  negative_code;
		logic [7:0]  echo_level;
		logic [31:0] seed_out;
		logic [2:0]  response_length;
		logic [7:0]  open_level;
	} sak_rsp_t;

	// Classified command passed from front to back
	typedef struct packed {
		sak_op_t     op;
		logic [7:0]  level;
		logic [7:0]  want_level;
		logic        odd_level;
		logic        even_level;
		logic        klen_zero;
		logic        klen_match;
		logic [31:0] key;
		logic [31:0] fresh;
	} sak_cmd_t;

	// Right shift that aligns the mask to the seed's used bytes (at most four)
	function automatic int unsigned seed_shift(input int unsigned bytes);
		int unsigned eff;
		eff = (bytes > 4) ? 4 : bytes;
		return 8 * (4 - eff);
	endfunction

	// Bits of a 32-bit field that the seed occupies
	function automatic logic [31:0] seed_mask(input int unsigned bytes);
		logic [31:0] ones;
		ones = '1;
		return ones >> seed_shift(bytes);
	endfunction

endpackage

`default_nettype wire

### hdl/seed_key_security_access.sv
// Top level of the seed/key unlock engine: front classifier, command queue, back end.
// Depends on sak_pkg, sak_front, sak_fifo and sak_back.
`default_nettype none

// Seed/key security-access engine. Request words (request seed, send key,
// one-second tick, state clear) enter on a valid/ready channel, are
// classified by the front end and queued in a two-word command queue; the
// back end executes one command per clock and registers one response word,
// so with the response side ready the block sustains one word per cycle.
// The accepting edge writes the word into the queue; the back end then
// takes it once its response register is free or draining and loads that
// register, after which the response is valid. Throughput is set by the
// single back-end state update per cycle. Configuration writes are registered
// and must be made while no word is in flight.
module seed_key_security_access import sak_pkg::*; #(
	parameter int unsigned SEED_BYTES = 4,
	parameter int unsigned TIMER_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_ready,
	input  wire sak_req_t               req,
	output logic                        rsp_valid,
	input  wire logic                   rsp_ready,
	output sak_rsp_t                    rsp,
	input  wire logic                   cfg_write_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic     push_valid;
	logic     push_ready;
	sak_cmd_t push_cmd;
	logic     cmd_valid;
	logic     cmd_ready;
	sak_cmd_t cmd;

	// Classification
	sak_front #(
		.SEED_BYTES(SEED_BYTES)
	) u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.cmd       (push_cmd)
	);

	// Decoupling queue
	sak_fifo #(
		.WIDTH($bits(sak_cmd_t)),
		.DEPTH(2)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_cmd),
		.pop_valid (cmd_valid),
		.pop_ready (cmd_ready),
		.pop_data  (cmd)
	);

	// Execution and response
	sak_back #(
		.SEED_BYTES(SEED_BYTES),
		.TIMER_BITS(TIMER_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

endmodule

`default_nettype wire

### hdl/sak_front.sv
// Front end: takes request words and classifies them into commands.
// Depends on sak_pkg.
`default_nettype none

module sak_front import sak_pkg::*; #(
	parameter int unsigned SEED_BYTES = 4
) (
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire sak_req_t req,
	output logic          push_valid,
	input  wire logic     push_ready,
	output sak_cmd_t      cmd
);

	localparam logic [31:0] MASK = seed_mask(SEED_BYTES);
	localparam logic [7:0]  KLEN = 8'(SEED_BYTES);

	// Handshake goes straight to the queue
	assign push_valid = req_valid;
	assign req_ready  = push_ready;

	// Decode level parity, length checks and seed-width masking
	always_comb begin
		cmd.op         = sak_op_t'(req.operation);
		cmd.level      = req.sub_function;
		cmd.want_level = req.sub_function - 8'd1;
		cmd.odd_level  = (req.sub_function != 8'd0) && req.sub_function[0];
		cmd.even_level = (req.sub_function != 8'd0) && !req.sub_function[0];
		cmd.klen_zero  = (req.key_length == 8'd0);
		cmd.klen_match = (req.key_length == KLEN);
		cmd.key        = req.key_value & MASK;
		cmd.fresh      = req.fresh_seed & MASK;
	end

endmodule

`default_nettype wire

### hdl/sak_fifo.sv
// Short flop-based command queue between front and back.
// Depends on sak_pkg and the assertion macro header.
`default_nettype none
`include "seed_key_security_access_macros.svh"

module sak_fifo import sak_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_fire) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop_fire) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Checks
	`SKSA_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop_ready && !pop_valid, !pop_fire, "pop from empty queue")
	`SKSA_ASSERT_NXT(a_count_up, clk, arst_n, push_fire && !pop_fire, count_q == CW'($past(count_q) + 1'b1), "fill count did not rise on push")
	`SKSA_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "fill count above depth")

endmodule

`default_nettype wire

### hdl/sak_back.sv
// Back end: configuration registers, unlock state and the registered response.
// Depends on sak_pkg and the assertion macro header.
`default_nettype none
`include "seed_key_security_access_macros.svh"

module sak_back import sak_pkg::*; #(
	parameter int unsigned SEED_BYTES = 4,
	parameter int unsigned TIMER_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cmd_valid,
	output logic                        cmd_ready,
	input  wire sak_cmd_t               cmd,
	output logic                        rsp_valid,
	input  wire logic                   rsp_ready,
	output sak_rsp_t                    rsp,
	input  wire logic                   cfg_write_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned CW        = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam int unsigned SH        = seed_shift(SEED_BYTES);
	localparam logic [31:0] MASK      = seed_mask(SEED_BYTES);
	localparam logic [2:0]  RLEN_SEED = 3'((2 + SEED_BYTES) % 8);
	localparam logic [2:0]  RLEN_KEY  = 3'd2;

	// Configuration
	logic [15:0] lockout_q;
	logic [15:0] timeout_q;
	logic [7:0]  attempts_q;
	logic [31:0] key_mask_q;

	// Unlock state
	logic [31:0]           seed_q;
	logic                  seed_valid_q;
	logic [7:0]            pending_q;
	logic [7:0]            granted_q;
	logic [7:0]            fail_cnt_q;
	logic                  lock_q;
	logic [TIMER_BITS-1:0] lock_age_q;
	logic [TIMER_BITS-1:0] seed_age_q;

	logic [31:0]           seed_d;
	logic                  seed_valid_d;
	logic [7:0]            pending_d;
	logic [7:0]            granted_d;
	logic [7:0]            fail_cnt_d;
	logic                  lock_d;
	logic [TIMER_BITS-1:0] lock_age_d;
	logic [TIMER_BITS-1:0] seed_age_d;

	logic                  rsp_valid_q;
	sak_rsp_t              rsp_q;
	sak_rsp_t              rsp_d;
	logic                  fire;
	logic                  lock_expired;
	logic                  lock_holds;
	logic                  seed_stale;
	logic [7:0]            fail_base;
	logic [7:0]            fail_inc;
	logic [31:0]           expect_key;

	// Take a command whenever the response register is free or draining
	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign fire      = cmd_valid && cmd_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Shared compares
	assign lock_expired = lock_q && (CW'(lock_age_q) >= CW'(lockout_q));
	assign lock_holds   = lock_q && !lock_expired;
	assign seed_stale   = (CW'(seed_age_q) >= CW'(timeout_q));
	assign fail_base    = lock_expired ? 8'd0 : fail_cnt_q;
	assign fail_inc     = (fail_base != 8'hFF) ? fail_base + 8'd1 : fail_base;
	assign expect_key   = (seed_q ^ (key_mask_q >> SH)) & MASK;

	// Command execution
	always_comb begin
		seed_d       = seed_q;
		seed_valid_d = seed_valid_q;
		pending_d    = pending_q;
		granted_d    = granted_q;
		fail_cnt_d   = fail_cnt_q;
		lock_d       = lock_q;
		lock_age_d   = lock_age_q;
		seed_age_d   = seed_age_q;

		rsp_d.status          = ST_POS;
		rsp_d.negative_code   = NRC_NONE;
		rsp_d.echo_level      = 8'd0;
		rsp_d.seed_out        = 32'd0;
		rsp_d.response_length = 3'd0;

		case (cmd.op)
			OP_SEED: begin
				if (!cmd.odd_level) begin
					rsp_d.status        = ST_NEG;
					rsp_d.negative_code = NRC_SUBFN;
				end else begin
					if (lock_expired) begin
						lock_d     = 1'b0;
						fail_cnt_d = 8'd0;
					end
					if (lock_holds) begin
						rsp_d.status        = ST_NEG;
						rsp_d.negative_code = NRC_ATTEMPTS;
					end else if (granted_q == cmd.level) begin
						rsp_d.echo_level      = cmd.level;
						rsp_d.response_length = RLEN_SEED;
					end else begin
						seed_d                = cmd.fresh;
						seed_valid_d          = 1'b1;
						pending_d             = cmd.level;
						seed_age_d            = '0;
						rsp_d.echo_level      = cmd.level;
						rsp_d.seed_out        = cmd.fresh;
						rsp_d.response_length = RLEN_SEED;
					end
				end
			end
			OP_KEY: begin
				if (cmd.klen_zero) begin
					rsp_d.status = ST_PARAM;
				end else if (!cmd.even_level) begin
					rsp_d.status        = ST_NEG;
					rsp_d.negative_code = NRC_SUBFN;
				end else begin
					if (lock_expired) begin
						lock_d     = 1'b0;
						fail_cnt_d = 8'd0;
					end
					if (lock_holds) begin
						rsp_d.status        = ST_NEG;
						rsp_d.negative_code = NRC_ATTEMPTS;
					end else if (!seed_valid_q || (pending_q != cmd.want_level)) begin
						rsp_d.status        = ST_NEG;
						rsp_d.negative_code = NRC_SEQUENCE;
					end else if (seed_stale) begin
						seed_valid_d        = 1'b0;
						rsp_d.status        = ST_NEG;
						rsp_d.negative_code = NRC_DELAY;
					end else if (!cmd.klen_match) begin
						rsp_d.status        = ST_NEG;
						rsp_d.negative_code = NRC_LENGTH;
					end else if (cmd.key != expect_key) begin
						// wrong key: count it, maybe lock out
						seed_valid_d = 1'b0;
						fail_cnt_d   = fail_inc;
						rsp_d.status = ST_NEG;
						if (fail_inc >= attempts_q) begin
							lock_d              = 1'b1;
							lock_age_d          = '0;
							rsp_d.negative_code = NRC_ATTEMPTS;
						end else begin
							rsp_d.negative_code = NRC_KEY;
						end
					end else begin
						seed_valid_d          = 1'b0;
						fail_cnt_d            = 8'd0;
						granted_d             = cmd.want_level;
						rsp_d.echo_level      = cmd.level;
						rsp_d.response_length = RLEN_KEY;
					end
				end
			end
			OP_TICK: begin
				if (seed_age_q != '1) begin
					seed_age_d = seed_age_q + 1'b1;
				end
				if (lock_age_q != '1) begin
					lock_age_d = lock_age_q + 1'b1;
				end
			end
			OP_CLEAR: begin
				seed_d       = 32'd0;
				seed_valid_d = 1'b0;
				pending_d    = 8'd0;
				granted_d    = 8'd0;
				fail_cnt_d   = 8'd0;
				lock_d       = 1'b0;
				lock_age_d   = '0;
				seed_age_d   = '0;
			end
			default: begin
			end
		endcase

		rsp_d.open_level = granted_d;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q  <= LOCKOUT_RESET;
			timeout_q  <= TIMEOUT_RESET;
			attempts_q <= ATTEMPTS_RESET;
			key_mask_q <= KEY_MASK_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_LOCKOUT:  lockout_q  <= cfg_data[15:0];
				REG_TIMEOUT:  timeout_q  <= cfg_data[15:0];
				REG_ATTEMPTS: attempts_q <= cfg_data[7:0];
				REG_MASK:     key_mask_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Unlock state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q       <= 32'd0;
			seed_valid_q <= 1'b0;
			pending_q    <= 8'd0;
			granted_q    <= 8'd0;
			fail_cnt_q   <= 8'd0;
			lock_q       <= 1'b0;
			lock_age_q   <= '0;
			seed_age_q   <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (fire) begin
				seed_q       <= seed_d;
				seed_valid_q <= seed_valid_d;
				pending_q    <= pending_d;
				granted_q    <= granted_d;
				fail_cnt_q   <= fail_cnt_d;
				lock_q       <= lock_d;
				lock_age_q   <= lock_age_d;
				seed_age_q   <= seed_age_d;
				rsp_valid_q  <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	// Checks
	`SKSA_ASSERT_IMP(a_lock_has_failures, clk, arst_n, lock_q, fail_cnt_q != 8'd0, "lockout without failures")
	`SKSA_ASSERT_IMP(a_pending_odd, clk, arst_n, seed_valid_q, pending_q[0], "valid seed for even level")
	`SKSA_ASSERT_IMP(a_granted_odd, clk, arst_n, granted_q != 8'd0, granted_q[0], "even level unlocked")

endmodule

`default_nettype wire
